// File: design/radar_report_deframer_assert.svh
// Assertion macros shared by the radar report deframer modules.
// No dependencies; included inside module bodies.
`ifndef RADAR_REPORT_DEFRAMER_ASSERT_SVH
`define RADAR_REPORT_DEFRAMER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define RRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RRD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rrd_pkg.sv
// Shared constants, types and helpers for the radar report deframer.
// No dependencies.
package rrd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_CNT_W       = 32;

    // Frame layout
    localparam logic [4:0] HDR_LEN    = 5'd4;
    localparam logic [4:0] SLOT1_BASE = 5'd12;
    localparam logic [4:0] SLOT2_BASE = 5'd20;
    localparam logic [4:0] SLOT_END   = 5'd28;
    localparam logic [4:0] TAIL_A_POS = 5'd28;
    localparam logic [4:0] TAIL_B_POS = 5'd29;

    localparam logic [7:0] HDR_B0 = 8'hAA;
    localparam logic [7:0] HDR_B1 = 8'hFF;
    localparam logic [7:0] HDR_B2 = 8'h03;
    localparam logic [7:0] HDR_B3 = 8'h00;
    localparam logic [7:0] TAIL_A = 8'h55;
    localparam logic [7:0] TAIL_B = 8'hCC;

    // One status result per received byte
    typedef struct packed {
        logic                 header_found;
        logic                 frame_done;
        logic                 frame_valid;
        logic [1:0]           target_count;
        logic [OUT_CNT_W-1:0] bytes_seen;
        logic [OUT_CNT_W-1:0] headers_seen;
        logic [OUT_CNT_W-1:0] good_frames;
        logic [OUT_CNT_W-1:0] bad_frames;
    } t_result;

    // Expected header byte for a given match progress
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = HDR_B0;
            2'd1: b = HDR_B1;
            2'd2: b = HDR_B2;
            default: b = HDR_B3;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] pop3(input logic [2:0] f);
        return 2'({1'b0, f[0]} + {1'b0, f[1]} + {1'b0, f[2]});
    endfunction

endpackage

// File: design/radar_report_deframer.sv
// Radar report deframer top level: input register, frame core, result register.
// Depends on rrd_pkg, rrd_core and radar_report_deframer_assert.svh.
//
// Usage:
//   Input channel i_valid / o_ready carries one received byte (i_rx_byte) per
//   transaction. Output channel o_valid / i_ready carries one status result per
//   byte: header/frame flags, the target count of the latest good frame and
//   four wrapping counters (low 32 bits of COUNT_WIDTH-bit counters).
//   Each byte passes two register stages (input register, then result
//   register) before its result shows.
//   Throughput: one byte per cycle while not stalled; the frame core updates
//   its state in a single pass between the input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; o_ready falls only when both are full.
//   Synchronous active-low reset clears all frame state, counters and both
//   valid flags; the block accepts bytes in the first cycle after reset.
//
module radar_report_deframer #(
    parameter int COUNT_WIDTH = rrd_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_header_found,
    output logic        o_frame_done,
    output logic        o_frame_valid,
    output logic [1:0]  o_target_count,
    output logic [31:0] o_bytes_seen,
    output logic [31:0] o_headers_seen,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames
);
    import rrd_pkg::*;
    `include "radar_report_deframer_assert.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_res;
    logic       adv;

    // Result stage can take a new item when empty or being drained
    assign adv     = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rrd_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (r_in_valid && adv),
        .i_byte (r_in_byte),
        .o_res  (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out <= core_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_header_found = r_out.header_found;
    assign o_frame_done   = r_out.frame_done;
    assign o_frame_valid  = r_out.frame_valid;
    assign o_target_count = r_out.target_count;
    assign o_bytes_seen   = r_out.bytes_seen;
    assign o_headers_seen = r_out.headers_seen;
    assign o_good_frames  = r_out.good_frames;
    assign o_bad_frames   = r_out.bad_frames;

    `RRD_ASSERT(a_valid_needs_done, i_clk, i_rst_n, o_valid |-> (!o_frame_valid || o_frame_done), "frame_valid without frame_done")
    `RRD_ASSERT(a_hdr_not_done, i_clk, i_rst_n, o_valid |-> !(o_header_found && o_frame_done), "header and frame end on one byte")
    `RRD_ASSERT_ALWAYS(a_ready_when_empty, i_clk, (!r_out_valid || !r_in_valid) |-> o_ready, "not ready with a free stage")
endmodule

// File: design/rrd_core.sv
// Frame tracking state and counters for the radar report deframer.
// Depends on rrd_pkg and radar_report_deframer_assert.svh.
module rrd_core #(
    parameter int COUNT_WIDTH = rrd_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output rrd_pkg::t_result o_res
);
    import rrd_pkg::*;
    `include "radar_report_deframer_assert.svh"

    logic [1:0]             r_hdr_prog, n_hdr_prog;
    logic [4:0]             r_pos, n_pos;
    logic [2:0]             r_flags, n_flags;
    logic                   r_tail_ok, n_tail_ok;
    logic [1:0]             r_last_tc, n_last_tc;
    logic [COUNT_WIDTH-1:0] r_bytes, n_bytes;
    logic [COUNT_WIDTH-1:0] r_hdrs, n_hdrs;
    logic [COUNT_WIDTH-1:0] r_good, n_good;
    logic [COUNT_WIDTH-1:0] r_bad, n_bad;
    logic                   hfound, done, valid;

    // Per-byte next state and status
    always_comb begin
        n_hdr_prog = r_hdr_prog;
        n_pos      = r_pos;
        n_flags    = r_flags;
        n_tail_ok  = r_tail_ok;
        n_last_tc  = r_last_tc;
        n_bytes    = r_bytes + COUNT_WIDTH'(1);
        n_hdrs     = r_hdrs;
        n_good     = r_good;
        n_bad      = r_bad;
        hfound     = 1'b0;
        done       = 1'b0;
        valid      = 1'b0;
        if (r_pos != 5'd0) begin
            // inside a frame: slot flags, tail check
            if (i_byte != 8'h00 && r_pos >= HDR_LEN && r_pos < SLOT_END) begin
                priority if (r_pos < SLOT1_BASE) begin
                    n_flags[0] = 1'b1;
                end else if (r_pos < SLOT2_BASE) begin
                    n_flags[1] = 1'b1;
                end else begin
                    n_flags[2] = 1'b1;
                end
            end
            if (r_pos == TAIL_A_POS) begin
                n_tail_ok = (i_byte == TAIL_A);
            end
            if (r_pos >= TAIL_B_POS) begin
                done       = 1'b1;
                n_pos      = 5'd0;
                n_hdr_prog = 2'd0;
                if (r_tail_ok && i_byte == TAIL_B) begin
                    valid     = 1'b1;
                    n_good    = r_good + COUNT_WIDTH'(1);
                    n_last_tc = pop3(r_flags);
                end else begin
                    n_bad = r_bad + COUNT_WIDTH'(1);
                end
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end else begin
            // header hunt
            if (i_byte == hdr_byte(r_hdr_prog)) begin
                if (r_hdr_prog == 2'd3) begin
                    hfound     = 1'b1;
                    n_hdrs     = r_hdrs + COUNT_WIDTH'(1);
                    n_hdr_prog = 2'd0;
                    n_pos      = HDR_LEN;
                    n_flags    = 3'd0;
                    n_tail_ok  = 1'b0;
                end else begin
                    n_hdr_prog = r_hdr_prog + 2'd1;
                end
            end else begin
                n_hdr_prog = (i_byte == HDR_B0) ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_prog <= '0;
            r_pos      <= '0;
            r_flags    <= '0;
            r_tail_ok  <= 1'b0;
            r_last_tc  <= '0;
            r_bytes    <= '0;
            r_hdrs     <= '0;
            r_good     <= '0;
            r_bad      <= '0;
        end else if (i_fire) begin
            r_hdr_prog <= n_hdr_prog;
            r_pos      <= n_pos;
            r_flags    <= n_flags;
            r_tail_ok  <= n_tail_ok;
            r_last_tc  <= n_last_tc;
            r_bytes    <= n_bytes;
            r_hdrs     <= n_hdrs;
            r_good     <= n_good;
            r_bad      <= n_bad;
        end
    end

    // Result fields show the low 32 bits of each counter
    always_comb begin
        o_res.header_found = hfound;
        o_res.frame_done   = done;
        o_res.frame_valid  = valid;
        o_res.target_count = n_last_tc;
        o_res.bytes_seen   = OUT_CNT_W'(n_bytes);
        o_res.headers_seen = OUT_CNT_W'(n_hdrs);
        o_res.good_frames  = OUT_CNT_W'(n_good);
        o_res.bad_frames   = OUT_CNT_W'(n_bad);
    end

    `RRD_ASSERT(a_pos_range, i_clk, i_rst_n, (r_pos == 5'd0) || (r_pos >= HDR_LEN && r_pos <= TAIL_B_POS), "frame position out of range")
    `RRD_ASSERT(a_hunt_idle, i_clk, i_rst_n, (r_pos != 5'd0) |-> (r_hdr_prog == 2'd0), "header progress kept inside a frame")
    `RRD_ASSERT(a_hdr_starts, i_clk, i_rst_n, (i_fire && hfound) |=> (r_pos == HDR_LEN && r_flags == 3'd0), "frame did not start after header")
endmodule
